// File: sv/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared types, fixed-point constants and the reciprocal table used by the
// pipelined dividers.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	// Hue is kept in 1/64 degree units.
	localparam int unsigned HUE_SCALE    = 64;
	localparam int unsigned SIXTY_FIXED  = 60 * HUE_SCALE;
	localparam int unsigned OFF_GREEN    = 120 * HUE_SCALE;
	localparam int unsigned OFF_BLUE     = 240 * HUE_SCALE;
	localparam int unsigned FULL_TURN    = 360 * HUE_SCALE;
	// Saturation full scale, 255 in 1/256 units.
	localparam int unsigned SAT_FULL     = 'hff * 256;

	// Reciprocal precision: numerators are below 2**RECIP_SHIFT.
	localparam int unsigned RECIP_SHIFT  = 24;
	localparam int unsigned NUM_W        = RECIP_SHIFT;
	localparam int unsigned RECIP_W      = RECIP_SHIFT + 1;
	localparam int unsigned QUOT_W       = 16;
	localparam int unsigned REM_W        = 10;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// Result of the channel comparison stage.
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] delta;
		logic [7:0] abs_num;
		logic       neg;
		sector_t    sector;
		logic       gray;
	} class_t;

	// Result of one divider.
	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic              rem_nz;
	} div_res_t;

	typedef logic [RECIP_W-1:0] recip_t;
	typedef recip_t recip_tbl_t [256];

	// floor(2**RECIP_SHIFT / d) for every 8-bit divisor, zero for d = 0.
	// Worked out bit by bit at elaboration.
	function automatic recip_tbl_t build_recip();
		recip_tbl_t  tbl;
		int unsigned rem;
		recip_t      q;
		for (int d = 0; d < 256; d++) begin
			rem = 0;
			q   = '0;
			for (int i = RECIP_W - 1; i >= 0; i--) begin
				rem = rem * 2 + ((i == RECIP_SHIFT) ? 1 : 0);
				if (d != 0 && rem >= d) begin
					rem  = rem - d;
					q[i] = 1'b1;
				end
			end
			tbl[d] = q;
		end
		return tbl;
	endfunction

	localparam recip_tbl_t RECIP_TBL = build_recip();

endpackage

// File: sv/rhsv_if.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter channels
// Valid/ready channels for the packed colour input and the HSV result.
// ----------------------------------------------------------------------------
interface rhsv_rgb_if;
	logic        valid;
	logic        ready;
	logic [23:0] color_word;

	modport source (output valid, output color_word, input ready);
	modport sink (input valid, input color_word, output ready);
endinterface

interface rhsv_hsv_if;
	logic        valid;
	logic        ready;
	logic [14:0] hue_fixed;
	logic [15:0] saturation_fixed;
	logic [7:0]  value_level;

	modport source (output valid, output hue_fixed, output saturation_fixed,
		output value_level, input ready);
	modport sink (input valid, input hue_fixed, input saturation_fixed,
		input value_level, output ready);
endinterface

// File: sv/rhsv_classify.sv
// ----------------------------------------------------------------------------
// RGB to HSV channel classifier
// Finds maximum, minimum and hue sector of one colour and the signed
// channel difference that feeds the hue division.
// ----------------------------------------------------------------------------
module rhsv_classify import rhsv_pkg::*; (
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output class_t     cls
);

	logic [7:0] mx;
	logic [7:0] mn;
	logic [8:0] diff;
	sector_t    sec;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
	end

	// Green wins a tie for the maximum, then blue, then red.
	always_comb begin
		if (green == mx) begin
			sec  = SEC_GREEN;
			diff = {1'b0, blue} - {1'b0, red};
		end else if (blue == mx) begin
			sec  = SEC_BLUE;
			diff = {1'b0, red} - {1'b0, green};
		end else begin
			sec  = SEC_RED;
			diff = {1'b0, green} - {1'b0, blue};
		end
	end

	always_comb begin
		cls.value   = mx;
		cls.delta   = mx - mn;
		cls.gray    = (mx == mn);
		cls.sector  = sec;
		cls.neg     = diff[8];
		cls.abs_num = diff[8] ? 8'(-diff) : diff[7:0];
	end

endmodule

// File: sv/rhsv_recip_div.sv
// ----------------------------------------------------------------------------
// RGB to HSV reciprocal divider
// Three-stage unsigned divider of a 24-bit numerator by an 8-bit divisor:
// reciprocal lookup, multiply, remainder, then a one-step correction.
// ----------------------------------------------------------------------------
module rhsv_recip_div import rhsv_pkg::*; (
	input  logic             clk,
	input  logic [2:0]       en,
	input  logic [NUM_W-1:0] num,
	input  logic [7:0]       den,
	output div_res_t         res
);

	logic [NUM_W-1:0]          num_s3;
	logic [7:0]                den_s3;
	recip_t                    rcp_s3;
	logic [NUM_W-1:0]          num_s4;
	logic [7:0]                den_s4;
	logic [QUOT_W-1:0]         qest_s4;
	logic [7:0]                den_s5;
	logic [QUOT_W-1:0]         qest_s5;
	logic [REM_W-1:0]          rem_s5;

	logic [NUM_W+RECIP_W-1:0]  prod;
	logic [NUM_W-1:0]          qd;
	logic [NUM_W-1:0]          rem_full;
	logic                      ge;
	logic [REM_W-1:0]          rem_fix;

	// The estimate is the true quotient or one below it.
	assign prod     = (NUM_W+RECIP_W)'(num_s3) * (NUM_W+RECIP_W)'(rcp_s3);
	assign qd       = NUM_W'(qest_s4) * NUM_W'(den_s4);
	assign rem_full = num_s4 - qd;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_s3 <= num;
			den_s3 <= den;
			rcp_s3 <= RECIP_TBL[den];
		end
		if (en[1]) begin
			num_s4  <= num_s3;
			den_s4  <= den_s3;
			qest_s4 <= prod[RECIP_SHIFT +: QUOT_W];
		end
		if (en[2]) begin
			den_s5  <= den_s4;
			qest_s5 <= qest_s4;
			rem_s5  <= rem_full[REM_W-1:0];
		end
	end

	always_comb begin
		ge         = (rem_s5 >= REM_W'(den_s5));
		res.quot   = qest_s5 + QUOT_W'(ge);
		rem_fix    = ge ? (rem_s5 - REM_W'(den_s5)) : rem_s5;
		res.rem_nz = (rem_fix != '0);
	end

endmodule

// File: sv/rhsv_assemble.sv
// ----------------------------------------------------------------------------
// RGB to HSV result assembly
// Adds the sector offset to the hue quotient, wraps negative hues and
// forces gray pixels to zero hue and saturation.
// ----------------------------------------------------------------------------
module rhsv_assemble import rhsv_pkg::*; (
	input  class_t      cls,
	input  div_res_t    hue_div,
	input  div_res_t    sat_div,
	output logic [14:0] hue,
	output logic [15:0] sat
);

	logic [15:0] offset;
	logic [12:0] q13;
	logic [12:0] mag;
	logic [15:0] diff;
	logic [15:0] hue_w;

	always_comb begin
		case (cls.sector)
			SEC_GREEN: offset = 16'(OFF_GREEN);
			SEC_BLUE:  offset = 16'(OFF_BLUE);
			SEC_RED:   offset = '0;
			default:   offset = '0;
		endcase
	end

	// A negative difference rounds towards minus infinity, so a non-zero
	// remainder adds one to the magnitude taken off the offset.
	always_comb begin
		q13  = hue_div.quot[12:0];
		mag  = q13 + 13'(hue_div.rem_nz);
		diff = offset - 16'(mag);
		if (!cls.neg) begin
			hue_w = offset + 16'(q13);
		end else if (diff[15]) begin
			hue_w = diff + 16'(FULL_TURN);
		end else begin
			hue_w = diff;
		end
		hue = cls.gray ? '0 : hue_w[14:0];
		sat = cls.gray ? '0 : sat_div.quot;
	end

endmodule

// File: sv/rgb_to_hsv_pixel_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one packed 24-bit colour per item into fixed-point hue,
// saturation and value through a six-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  ------------------------------------------------------
//  pixel    in         color_word[23:0]: red 7:0, green 15:8, blue 23:16
//  hsv      out        hue_fixed[14:0], saturation_fixed[15:0], value_level[7:0]
//
// One item is accepted per clock while the hsv side keeps taking results;
// the depth is set by the reciprocal dividers, which take a table lookup,
// a wide multiply and a remainder multiply in separate stages.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled, so a stall
// on the hsv side fills empty stages first and drops or repeats no item.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_converter import rhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rhsv_rgb_if.sink   pixel,
	rhsv_hsv_if.source hsv
);

	// Stage valid bits and per-stage ready. A stage may load when it is
	// empty or when the stage after it is loading as well.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5, ready_s6;

	assign ready_s6 = !valid_s6 || hsv.ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign pixel.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= pixel.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: the input register.
	logic [23:0] rgb_s1;

	always_ff @(posedge clk) begin
		if (ready_s1) rgb_s1 <= pixel.color_word;
	end

	// Stage 2: maximum, minimum, sector and channel difference.
	class_t cls_d;
	class_t cls_s2, cls_s3, cls_s4, cls_s5;

	rhsv_classify u_classify (
		.red   (rgb_s1[7:0]),
		.green (rgb_s1[15:8]),
		.blue  (rgb_s1[23:16]),
		.cls   (cls_d)
	);

	// The sideband copy of the classification follows the dividers.
	always_ff @(posedge clk) begin
		if (ready_s2) cls_s2 <= cls_d;
		if (ready_s3) cls_s3 <= cls_s2;
		if (ready_s4) cls_s4 <= cls_s3;
		if (ready_s5) cls_s5 <= cls_s4;
	end

	// Stages 3 to 5: the hue divides 3840 times the channel difference by
	// max - min, and the saturation divides 65280 times max - min by max.
	logic [NUM_W-1:0] hue_num;
	logic [NUM_W-1:0] sat_num;
	logic [2:0]       div_en;
	div_res_t         hue_div;
	div_res_t         sat_div;

	assign hue_num = NUM_W'(cls_s2.abs_num) * NUM_W'(SIXTY_FIXED);
	assign sat_num = NUM_W'(cls_s2.delta) * NUM_W'(SAT_FULL);
	assign div_en  = {ready_s5, ready_s4, ready_s3};

	rhsv_recip_div u_hue_div (
		.clk (clk),
		.en  (div_en),
		.num (hue_num),
		.den (cls_s2.delta),
		.res (hue_div)
	);

	rhsv_recip_div u_sat_div (
		.clk (clk),
		.en  (div_en),
		.num (sat_num),
		.den (cls_s2.value),
		.res (sat_div)
	);

	// Stage 6: sector offset, wrap and the output register.
	logic [14:0] hue_d;
	logic [15:0] sat_d;
	logic [14:0] hue_s6;
	logic [15:0] sat_s6;
	logic [7:0]  val_s6;

	rhsv_assemble u_assemble (
		.cls     (cls_s5),
		.hue_div (hue_div),
		.sat_div (sat_div),
		.hue     (hue_d),
		.sat     (sat_d)
	);

	always_ff @(posedge clk) begin
		if (ready_s6) begin
			hue_s6 <= hue_d;
			sat_s6 <= sat_d;
			val_s6 <= cls_s5.value;
		end
	end

	assign hsv.valid            = valid_s6;
	assign hsv.hue_fixed        = hue_s6;
	assign hsv.saturation_fixed = sat_s6;
	assign hsv.value_level      = val_s6;

	// A colourful pixel always has a saturation of at least 256, so a zero
	// saturation marks a gray pixel, whose hue must be zero as well.
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && (sat_s6 == '0) |-> (hue_s6 == '0))
		else $error("gray result with non-zero hue");

	// The wrap keeps the hue below one full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (hue_s6 < 15'(FULL_TURN)))
		else $error("hue beyond full turn");

	// Saturation never exceeds full scale, and full scale needs a black
	// minimum, so the value must then be non-zero.
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (sat_s6 <= 16'(SAT_FULL)) && ((sat_s6 == '0) || (val_s6 != '0)))
		else $error("saturation out of range");

endmodule

// File: test/hsv_conversion_monitor.sv
// ----------------------------------------------------------------------------
// HSV conversion monitor
// Watches the pixel and hsv channels of the RGB to HSV converter, works out
// the expected hue, saturation and value for every accepted pixel and
// compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
module hsv_conversion_monitor import rhsv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rhsv_rgb_if  pixel,
	rhsv_hsv_if  hsv,
	output int   pending_count,
	output int   fail_count
);

	typedef struct packed {
		logic [14:0] hue;
		logic [15:0] sat;
		logic [7:0]  val;
	} hsv_item_t;

	hsv_item_t expected_hsv [$];

	// Exact hue scaled by 64 and rounded towards minus infinity, then
	// wrapped into one full turn; saturation truncated.
	function automatic hsv_item_t predict_hsv(input logic [23:0] word);
		int        red, green, blue;
		int        hi, lo, span, diff, num, angle, base;
		sector_t   sec;
		hsv_item_t res;
		red   = int'(word[7:0]);
		green = int'(word[15:8]);
		blue  = int'(word[23:16]);
		hi    = red;
		lo    = red;
		if (green > hi) hi = green;
		if (blue > hi) hi = blue;
		if (green < lo) lo = green;
		if (blue < lo) lo = blue;
		res.val = hi[7:0];
		res.hue = '0;
		res.sat = '0;
		if (hi > lo) begin
			span = hi - lo;
			if (green == hi) sec = SEC_GREEN;
			else if (blue == hi) sec = SEC_BLUE;
			else sec = SEC_RED;
			case (sec)
				SEC_GREEN: begin
					diff = blue - red;
					base = int'(OFF_GREEN);
				end
				SEC_BLUE: begin
					diff = red - green;
					base = int'(OFF_BLUE);
				end
				default: begin
					diff = green - blue;
					base = 0;
				end
			endcase
			num = diff * int'(SIXTY_FIXED);
			if (num >= 0) angle = num / span;
			else angle = -((-num + span - 1) / span);
			angle = angle + base;
			if (angle < 0) angle = angle + int'(FULL_TURN);
			res.hue = angle[14:0];
			res.sat = 16'((span * int'(SAT_FULL)) / hi);
		end
		return res;
	endfunction

	task automatic report_failure(input string msg);
		$display("%0t: hsv mismatch: %s", $realtime, msg);
		fail_count = fail_count + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hsv_item_t want;
		if (!arst_n) begin
			expected_hsv.delete();
			fail_count    = 0;
			pending_count <= 0;
		end else begin
			// Results are taken first so that a pixel accepted in the same
			// cycle can never be matched against its own result.
			if (hsv.valid && hsv.ready) begin
				if (expected_hsv.size() == 0) begin
					report_failure($sformatf("result h=%0d s=%0d v=%0d with none pending",
						hsv.hue_fixed, hsv.saturation_fixed, hsv.value_level));
				end else begin
					want = expected_hsv.pop_front();
					if (hsv.hue_fixed !== want.hue)
						report_failure($sformatf("hue_fixed got %0d, want %0d",
							hsv.hue_fixed, want.hue));
					if (hsv.saturation_fixed !== want.sat)
						report_failure($sformatf("saturation_fixed got %0d, want %0d",
							hsv.saturation_fixed, want.sat));
					if (hsv.value_level !== want.val)
						report_failure($sformatf("value_level got %0d, want %0d",
							hsv.value_level, want.val));
				end
			end
			if (pixel.valid && pixel.ready)
				expected_hsv.push_back(predict_hsv(pixel.color_word));
			pending_count <= expected_hsv.size();
		end
	end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter testbench
// Drives directed and random colours into the converter under three idling
// patterns, with a long output stall and a full drain, and gives the verdict
// from the failure count of the conversion monitor.
// ----------------------------------------------------------------------------
module tb;

	// The limit leaves a wide margin over the slowest correct run for idling
	// on both sides and the long output stall.
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   pending_count;
	int   fail_count;

	// Idling percentages for the sender and the receiver, and the request
	// for one long stretch with the receiver holding off.
	int   src_idle_pct;
	int   sink_idle_pct;
	bit   hold_req;
	int   hold_left;

	// Directed colours: black, white and mid grey; the three primaries and
	// the three secondaries, where ties for the maximum decide the sector;
	// a red maximum with blue above green, so that the hue wraps past zero;
	// negative channel differences in the green and blue sectors; and the
	// smallest non-zero spread at both ends of the range.
	logic [23:0] directed_px [] = '{
		24'h000000, 24'hFFFFFF, 24'h808080,
		24'h0000FF, 24'h00FF00, 24'hFF0000,
		24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
		24'h0100FF, 24'h640AC8, 24'h32C864, 24'hC8640A,
		24'h000001, 24'h010100, 24'h010001, 24'hFEFFFF, 24'hFFFEFE,
		24'h7F8081, 24'hFF0001, 24'h00FF01
	};

	rhsv_rgb_if pixel_ch ();
	rhsv_hsv_if hsv_ch ();

	rgb_to_hsv_pixel_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.hsv    (hsv_ch)
	);

	hsv_conversion_monitor conv_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixel         (pixel_ch),
		.hsv           (hsv_ch),
		.pending_count (pending_count),
		.fail_count    (fail_count)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a run that has not finished by the limit has hung.
	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Colour generator. Most of the values are fully random, but a good
	// share is steered towards the interesting corners: grey pixels, ties
	// between two channels for the maximum, channels pinned to the rails,
	// and tiny spreads where the hue division is at its coarsest.
	function automatic logic [23:0] random_pixel();
		int kind, hi, lo, level, base;
		logic [7:0] r, g, b;
		kind = $urandom_range(9);
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case (kind)
			4: begin
				level = $urandom_range(255);
				r = 8'(level);
				g = 8'(level);
				b = 8'(level);
			end
			5: begin
				hi = $urandom_range(1, 255);
				lo = $urandom_range(0, hi - 1);
				case ($urandom_range(2))
					0: begin r = 8'(lo); g = 8'(hi); b = 8'(hi); end
					1: begin r = 8'(hi); g = 8'(lo); b = 8'(hi); end
					default: begin r = 8'(hi); g = 8'(hi); b = 8'(lo); end
				endcase
			end
			6: begin
				if ($urandom_range(2) == 0) r = 8'hFF; else if ($urandom_range(1) == 0) r = 8'h00;
				if ($urandom_range(2) == 0) g = 8'hFF; else if ($urandom_range(1) == 0) g = 8'h00;
				if ($urandom_range(2) == 0) b = 8'hFF; else if ($urandom_range(1) == 0) b = 8'h00;
			end
			7: begin
				base = $urandom_range(0, 252);
				r = 8'(base + $urandom_range(3));
				g = 8'(base + $urandom_range(3));
				b = 8'(base + $urandom_range(3));
			end
			default: ;
		endcase
		return {b, g, r};
	endfunction

	// Offers one item, after a random number of idle cycles, and returns
	// at the falling edge after it has been accepted. The valid line is
	// only ever written once per falling edge, so back-to-back items keep
	// it high without a glitch.
	task automatic send_pixel(input logic [23:0] color);
		while ($urandom_range(99) < src_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_ch.valid      <= 1'b1;
		pixel_ch.color_word <= color;
		do @(posedge clk); while (!pixel_ch.ready);
		@(negedge clk);
	endtask

	// Sender pause: stop offering and wait until every expected result has
	// come back, so that the pipeline is completely empty.
	task automatic drain_pipeline();
		pixel_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending_count == 0);
		@(negedge clk);
	endtask

	// Receiver. It normally stalls at random at the current idling rate;
	// when a long hold-off is requested it keeps ready low for a fixed
	// stretch, counted here, while the sender keeps offering items, which
	// fills every pipeline stage and pushes back on the pixel side.
	initial begin
		hsv_ch.ready = 1'b0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hsv_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				hsv_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Main stimulus. Reset is applied once; then the directed colours go
	// in, followed by three random phases with different idling patterns.
	initial begin
		pixel_ch.valid      = 1'b0;
		pixel_ch.color_word = '0;
		hold_req            = 1'b0;
		src_idle_pct        = 29;
		sink_idle_pct       = 67;
		arst_n              = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_px[i])
			send_pixel(directed_px[i]);

		// Sender idles less than the receiver: results back up often.
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_pixel(random_pixel());
		drain_pipeline();

		// The other way round: the pipeline mostly runs near empty. Half
		// way through the sender stops until everything has come back.
		src_idle_pct  = 67;
		sink_idle_pct = 29;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == PHASE_ITEMS / 2)
				drain_pipeline();
			send_pixel(random_pixel());
		end
		drain_pipeline();

		// Neither side idles, apart from one long stall on the hsv side
		// early in the phase.
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == 40)
				hold_req = 1'b1;
			send_pixel(random_pixel());
		end
		pixel_ch.valid <= 1'b0;

		// Wait for the last results, then keep the clock running so that the
		// block can show any result that should not be there.
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
